// ===== rtl/core/lps_pkg.sv =====
// Package for the line point stepper: coordinate widths, the command code,
// and the types shared by the stepper modules. No dependencies.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;

    typedef logic        [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } lps_func_t;

    // Complete line state held between transactions.
    typedef struct packed {
        coord_t major_pos;
        coord_t major_end;
        coord_t minor_pos;
        err_t   err_acc;
        coord_t delta_major;
        coord_t delta_minor;
        logic   steep;
        logic   major_down;
        logic   minor_down;
        logic   active;
    } lps_state_t;

    // One result transaction.
    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   point_valid;
        logic   last;
    } lps_point_t;

    // Occupancy of the result buffer.
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } lps_buf_status_t;

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic coord_t step_coord(input coord_t v, input logic down);
        return down ? (v - coord_t'(1)) : (v + coord_t'(1));
    endfunction

endpackage

// ===== rtl/core/lps_if.sv =====
// Valid/ready channel interfaces for the line point stepper: the command
// channel and the point channel. Depends on lps_pkg.
`timescale 1ns / 1ps

interface lps_cmd_if
    import lps_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   func;
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;

    modport source (output valid, func, from_x, from_y, to_x, to_y, input ready);
    modport sink   (input valid, func, from_x, from_y, to_x, to_y, output ready);
endinterface

interface lps_point_if
    import lps_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   point_valid;
    logic   last;

    modport source (output valid, point_x, point_y, point_valid, last, input ready);
    modport sink   (input valid, point_x, point_y, point_valid, last, output ready);
endinterface

// ===== rtl/core/lps_setup.sv =====
// Line setup logic: derives the axis swap, step directions, deltas and the
// initial error from a start command. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_setup
    import lps_pkg::*;
(
    input  coord_t     from_x,
    input  coord_t     from_y,
    input  coord_t     to_x,
    input  coord_t     to_y,
    output lps_state_t setup_state
);

    coord_t dx;
    coord_t dy;
    logic   steep;

    assign dx    = abs_diff(to_x, from_x);
    assign dy    = abs_diff(to_y, from_y);
    assign steep = dy > dx;

    always_comb
    begin
        setup_state.steep = steep;
        if (steep)
        begin
            setup_state.major_pos   = from_y;
            setup_state.major_end   = to_y;
            setup_state.minor_pos   = from_x;
            setup_state.delta_major = dy;
            setup_state.delta_minor = dx;
            setup_state.major_down  = from_y > to_y;
            setup_state.minor_down  = from_x > to_x;
        end
        else
        begin
            setup_state.major_pos   = from_x;
            setup_state.major_end   = to_x;
            setup_state.minor_pos   = from_y;
            setup_state.delta_major = dx;
            setup_state.delta_minor = dy;
            setup_state.major_down  = from_x > to_x;
            setup_state.minor_down  = from_y > to_y;
        end
        // The error starts at half the major delta.
        setup_state.err_acc = err_t'({2'b00, setup_state.delta_major} >> 1);
        setup_state.active  = setup_state.delta_major != '0;
    end

endmodule

// ===== rtl/core/lps_step.sv =====
// Single Bresenham step: emits the current point and advances the line
// state by one position on the major axis. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_step
    import lps_pkg::*;
(
    input  lps_state_t cur_state,
    output lps_state_t step_state,
    output lps_point_t step_point
);

    err_t   err_dec;
    coord_t major_adv;

    assign err_dec   = cur_state.err_acc - err_t'({2'b00, cur_state.delta_minor});
    assign major_adv = step_coord(cur_state.major_pos, cur_state.major_down);

    always_comb
    begin
        step_state = cur_state;
        step_point = '0;
        if (cur_state.active)
        begin
            step_point.point_x     = cur_state.steep ? cur_state.minor_pos : cur_state.major_pos;
            step_point.point_y     = cur_state.steep ? cur_state.major_pos : cur_state.minor_pos;
            step_point.point_valid = 1'b1;

            if (err_dec < 0)
            begin
                step_state.minor_pos = step_coord(cur_state.minor_pos, cur_state.minor_down);
                step_state.err_acc   = err_dec + err_t'({2'b00, cur_state.delta_major});
            end
            else
            begin
                step_state.err_acc = err_dec;
            end

            step_state.major_pos = major_adv;
            if (major_adv == cur_state.major_end)
            begin
                step_point.last   = 1'b1;
                step_state.active = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/lps_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) so that the
// command side keeps a registered ready. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_out_buf
    import lps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lps_point_t      wr_data,
    output logic            wr_ready,
    output logic            rd_valid,
    input  logic            rd_ready,
    output lps_point_t      rd_data,
    output lps_buf_status_t status
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    lps_point_t out_data_reg;
    lps_point_t out_data_next;
    lps_point_t skid_data_reg;
    lps_point_t skid_data_next;

    assign wr_ready = !skid_valid_reg;
    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;
    assign status   = '{out_valid: out_valid_reg, skid_valid: skid_valid_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || rd_ready)
        begin
            // The output register is free this cycle; the skid entry is older.
            out_valid_next  = skid_valid_reg || wr_en;
            out_data_next   = skid_valid_reg ? skid_data_reg : wr_data;
            skid_valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/core/line_point_stepper.sv =====
// Top level of the line point stepper. Depends on lps_pkg, lps_if,
// lps_setup, lps_step and lps_out_buf.
`timescale 1ns / 1ps

// Bresenham line point generator. A start command (func 0) loads a line and
// returns an empty result; each step command (func 1) returns the next point of
// the active line, from the start point up to but not including the end point,
// with last set on the final one. Every accepted command returns exactly one
// result transaction, in order. One command is accepted per clock while
// cmd.ready is high: the line state is updated by a single add, compare and
// select in the cycle the command is taken, and the result is registered.
// A two-entry result buffer lets commands keep flowing while a result waits;
// cmd.ready drops only once both entries are full, and it comes from a register.

module line_point_stepper
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lps_cmd_if.sink     cmd,
    lps_point_if.source point
);

    lps_state_t      state_reg;
    lps_state_t      state_next;
    lps_state_t      setup_state;
    lps_state_t      step_state;
    lps_point_t      step_point;
    lps_point_t      result;
    lps_point_t      rd_data;
    lps_buf_status_t buf_status;
    logic            cmd_fire;
    logic            is_start;

    lps_setup u_setup (
        .from_x      (cmd.from_x),
        .from_y      (cmd.from_y),
        .to_x        (cmd.to_x),
        .to_y        (cmd.to_y),
        .setup_state (setup_state)
    );

    lps_step u_step (
        .cur_state  (state_reg),
        .step_state (step_state),
        .step_point (step_point)
    );

    assign cmd_fire = cmd.valid && cmd.ready;
    assign is_start = cmd.func == FUNC_START;

    always_comb
    begin
        state_next = state_reg;
        result     = '0;
        if (cmd_fire)
        begin
            if (is_start)
            begin
                state_next = setup_state;
            end
            else
            begin
                state_next = step_state;
                result     = step_point;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    lps_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_fire),
        .wr_data  (result),
        .wr_ready (cmd.ready),
        .rd_valid (point.valid),
        .rd_ready (point.ready),
        .rd_data  (rd_data),
        .status   (buf_status)
    );

    assign point.point_x     = rd_data.point_x;
    assign point.point_y     = rd_data.point_y;
    assign point.point_valid = rd_data.point_valid;
    assign point.last        = rd_data.last;

    // The skid entry is only ever used behind a held output entry.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid |-> buf_status.out_valid)
        else $error("skid entry valid while output register empty");

    // An active line never sits on its end point.
    a_active_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.active |-> (state_reg.major_pos != state_reg.major_end))
        else $error("active line positioned at its end point");

    // A start leaves the line active exactly when it has nonzero length.
    a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && is_start) |=> (state_reg.active == (state_reg.delta_major != '0)))
        else $error("start command loaded inconsistent active flag");

    // A result marked last always carries a point.
    a_last_has_point: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.last) |-> point.point_valid)
        else $error("last set on a result without a point");

endmodule
